>>> rtl/ast_pkg.sv
`timescale 1ns / 1ps
// Package for the assembly source tokenizer: token kinds, character codes,
// the word passed from the front end to the back end, and classification helpers.
// No dependencies.
package ast_pkg;

  typedef enum logic [3:0] {
    KIND_UNKNOWN  = 4'd0,
    KIND_MNEMONIC = 4'd1,
    KIND_HASH     = 4'd2,
    KIND_DOLLAR   = 4'd3,
    KIND_LPAREN   = 4'd4,
    KIND_RPAREN   = 4'd5,
    KIND_BYTE     = 4'd6,
    KIND_WORD     = 4'd7,
    KIND_REGISTER = 4'd8,
    KIND_COMMA    = 4'd9,
    KIND_END      = 4'd10
  } kind_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  localparam logic [2:0] RUN_MAX  = 3'd5;
  localparam logic [15:0] LINE_FIRST = 16'd1;
  localparam logic [15:0] LINE_MAX   = 16'hFFFF;

  // one queue word: an optional pending run token and an optional single token
  typedef struct packed {
    logic            run_valid;
    logic [2:0]      run_len;
    logic [3:0][7:0] run_chars;
    logic            tok_valid;
    kind_t           tok_kind;
    logic [7:0]      tok_char;
    logic [15:0]     line;
  } entry_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_lower(c) || is_upper(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (is_digit(c)) begin
      v = c[3:0];
    end else if (is_hex(c)) begin
      v = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return v;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_CR) ||
           (c == CH_NEWLINE);
  endfunction

  function automatic logic is_reg_letter(input logic [7:0] c);
    return (c == 8'h41) || (c == 8'h61) || (c == 8'h58) || (c == 8'h78) ||
           (c == 8'h59) || (c == 8'h79);
  endfunction

endpackage

>>> rtl/ast_fifo.sv
`timescale 1ns / 1ps
// Short word queue between the tokenizer front end and back end.
// Depends on ast_pkg (entry_t).
module ast_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  ast_pkg::entry_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output ast_pkg::entry_t rd_data,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ast_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !full)
    else $error("queue write while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");
  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && wr_en && !rd_en) |=> !empty)
    else $error("queue write lost");
`endif

endmodule

>>> rtl/ast_front.sv
`timescale 1ns / 1ps
// Tokenizer front end: takes characters, gathers alphanumeric runs, counts lines
// and writes one queue word per character that yields tokens. Depends on ast_pkg.
module ast_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [7:0]      in_char_in,
  input  logic            q_full,
  output logic            q_wr_en,
  output ast_pkg::entry_t q_wr_data
);

  logic [3:0][7:0] run_chars_r, run_chars_nxt;
  logic [2:0]      run_len_r, run_len_nxt;
  logic [15:0]     line_r, line_nxt;
  logic            accept;
  logic            alnum;
  ast_pkg::kind_t  kind;

  assign accept = push && !q_full;
  assign alnum  = ast_pkg::is_alnum(in_char_in);

  always_comb begin
    case (in_char_in)
      ast_pkg::CH_HASH:   kind = ast_pkg::KIND_HASH;
      ast_pkg::CH_DOLLAR: kind = ast_pkg::KIND_DOLLAR;
      ast_pkg::CH_LPAREN: kind = ast_pkg::KIND_LPAREN;
      ast_pkg::CH_RPAREN: kind = ast_pkg::KIND_RPAREN;
      ast_pkg::CH_COMMA:  kind = ast_pkg::KIND_COMMA;
      ast_pkg::CH_NUL:    kind = ast_pkg::KIND_END;
      default:            kind = ast_pkg::KIND_UNKNOWN;
    endcase
  end

  always_comb begin
    q_wr_data.run_valid = !alnum && (run_len_r != '0);
    q_wr_data.run_len   = run_len_r;
    q_wr_data.run_chars = run_chars_r;
    q_wr_data.tok_valid = !alnum && !ast_pkg::is_space(in_char_in);
    q_wr_data.tok_kind  = kind;
    q_wr_data.tok_char  = in_char_in;
    q_wr_data.line      = line_r;
    q_wr_en = accept && (q_wr_data.run_valid || q_wr_data.tok_valid);
  end

  always_comb begin
    run_chars_nxt = run_chars_r;
    run_len_nxt   = run_len_r;
    line_nxt      = line_r;
    if (accept) begin
      if (alnum) begin
        if (run_len_r < 3'd4) begin
          run_chars_nxt[run_len_r[1:0]] = in_char_in;
        end
        if (run_len_r < ast_pkg::RUN_MAX) begin
          run_len_nxt = run_len_r + 3'd1;
        end
      end else begin
        run_chars_nxt = '0;
        run_len_nxt   = '0;
        if (in_char_in == ast_pkg::CH_NEWLINE && line_r != ast_pkg::LINE_MAX) begin
          line_nxt = line_r + 16'd1;
        end else if (in_char_in == ast_pkg::CH_NUL) begin
          line_nxt = ast_pkg::LINE_FIRST;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_chars_r <= '0;
      run_len_r   <= '0;
      line_r      <= ast_pkg::LINE_FIRST;
    end else begin
      run_chars_r <= run_chars_nxt;
      run_len_r   <= run_len_nxt;
      line_r      <= line_nxt;
    end
  end

endmodule

>>> rtl/ast_back.sv
`timescale 1ns / 1ps
// Tokenizer back end: classifies pending runs, parses hex values and emits
// tokens through a one-word output register. Depends on ast_pkg.
module ast_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ast_pkg::entry_t q_rd_data,
  output logic            q_rd_en,
  output logic            empty,
  input  logic            pop,
  output logic [3:0]      out_token_kind,
  output logic [15:0]     out_token_value,
  output logic [7:0]      out_text_first,
  output logic [7:0]      out_text_second,
  output logic [7:0]      out_text_third,
  output logic [15:0]     out_line_number,
  output logic            out_last_of_run
);

  logic            valid_r;
  logic            run_done_r, run_done_nxt;
  ast_pkg::kind_t  kind_r, kind_nxt, run_kind;
  logic [15:0]     value_r, value_nxt, run_value;
  logic [7:0]      t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  logic [15:0]     line_r;
  logic            last_r, last_nxt;
  logic            emit_run, adv;
  logic [3:0][7:0] rc;
  logic [2:0]      rlen;

  assign rc   = q_rd_data.run_chars;
  assign rlen = q_rd_data.run_len;

  always_comb begin
    run_kind  = ast_pkg::KIND_UNKNOWN;
    run_value = '0;
    case (rlen)
      3'd1: begin
        if (ast_pkg::is_reg_letter(rc[0])) begin
          run_kind = ast_pkg::KIND_REGISTER;
        end
      end
      3'd2: begin
        if (ast_pkg::is_hex(rc[0]) && ast_pkg::is_hex(rc[1])) begin
          run_kind  = ast_pkg::KIND_BYTE;
          run_value = {8'd0, ast_pkg::hex_val(rc[0]), ast_pkg::hex_val(rc[1])};
        end
      end
      3'd3: begin
        run_kind = ast_pkg::KIND_MNEMONIC;
      end
      3'd4: begin
        if (ast_pkg::is_hex(rc[0]) && ast_pkg::is_hex(rc[1]) &&
            ast_pkg::is_hex(rc[2]) && ast_pkg::is_hex(rc[3])) begin
          run_kind  = ast_pkg::KIND_WORD;
          run_value = {ast_pkg::hex_val(rc[0]), ast_pkg::hex_val(rc[1]),
                       ast_pkg::hex_val(rc[2]), ast_pkg::hex_val(rc[3])};
        end
      end
      default: begin
        run_kind = ast_pkg::KIND_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    emit_run = q_rd_data.run_valid && !run_done_r;
    adv      = !q_empty && (!valid_r || pop);
    q_rd_en  = adv && !(emit_run && q_rd_data.tok_valid);
    if (emit_run) begin
      kind_nxt  = run_kind;
      value_nxt = run_value;
      t0_nxt    = rc[0];
      t1_nxt    = (rlen >= 3'd2) ? rc[1] : 8'd0;
      t2_nxt    = (rlen >= 3'd3) ? rc[2] : 8'd0;
      last_nxt  = !q_rd_data.tok_valid;
    end else begin
      kind_nxt  = q_rd_data.tok_kind;
      value_nxt = '0;
      t0_nxt    = q_rd_data.tok_char;
      t1_nxt    = 8'd0;
      t2_nxt    = 8'd0;
      last_nxt  = 1'b1;
    end
    run_done_nxt = run_done_r;
    if (adv) begin
      run_done_nxt = emit_run && q_rd_data.tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      run_done_r <= 1'b0;
    end else begin
      run_done_r <= run_done_nxt;
      if (adv) begin
        valid_r <= 1'b1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      t0_r    <= t0_nxt;
      t1_r    <= t1_nxt;
      t2_r    <= t2_nxt;
      line_r  <= q_rd_data.line;
      last_r  <= last_nxt;
    end
  end

  assign empty           = !valid_r;
  assign out_token_kind  = kind_r;
  assign out_token_value = value_r;
  assign out_text_first  = t0_r;
  assign out_text_second = t1_r;
  assign out_text_third  = t2_r;
  assign out_line_number = line_r;
  assign out_last_of_run = last_r;

endmodule

>>> rtl/assembly_source_tokenizer.sv
`timescale 1ns / 1ps
// Assembly source tokenizer, top level: front end, word queue, back end.
// A token reaches the result ports through the back end's output register, from the
// queue word written when its character (for a run, the one ending the run) is taken.
// Throughput: one character per cycle unless full; the back end emits one token per
// cycle unless its output is held; the queue absorbs characters that yield two tokens.
// Reset (rst_n low, synchronous): queue and output empty, run cleared, line set to 1.
module assembly_source_tokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_in,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_value,
  output logic [7:0]  out_text_first,
  output logic [7:0]  out_text_second,
  output logic [7:0]  out_text_third,
  output logic [15:0] out_line_number,
  output logic        out_last_of_run
);

  logic            q_wr_en, q_rd_en, q_full, q_empty;
  ast_pkg::entry_t q_wr_data, q_rd_data;

  assign full = q_full;

  ast_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_char_in (in_char_in),
    .q_full     (q_full),
    .q_wr_en    (q_wr_en),
    .q_wr_data  (q_wr_data)
  );

  ast_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  ast_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rd_data       (q_rd_data),
    .q_rd_en         (q_rd_en),
    .empty           (empty),
    .pop             (pop),
    .out_token_kind  (out_token_kind),
    .out_token_value (out_token_value),
    .out_text_first  (out_text_first),
    .out_text_second (out_text_second),
    .out_text_third  (out_text_third),
    .out_line_number (out_line_number),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> test/assembly_source_tokenizer_checker.sv
`timescale 1ns / 1ps
// Token checker for the assembly source tokenizer: watches both queue ports, predicts the
// tokens of every character taken and compares each popped word field by field.
// Depends on ast_pkg for the token kinds and character codes.
module tokenizer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  char_in,
  input  logic        empty,
  input  logic        pop,
  input  logic [3:0]  token_kind,
  input  logic [15:0] token_value,
  input  logic [7:0]  text_first,
  input  logic [7:0]  text_second,
  input  logic [7:0]  text_third,
  input  logic [15:0] line_number,
  input  logic        last_of_run,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct {
    ast_pkg::kind_t kind;
    logic [15:0]    value;
    logic [7:0]     first;
    logic [7:0]     second;
    logic [7:0]     third;
    logic [15:0]    line;
    logic           last;
  } token_t;

  token_t      expected_tokens[$];
  logic [7:0]  run_buf[4];
  logic [2:0]  run_len;
  logic [15:0] line_cnt;

  function automatic logic alnum_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
    return v[3:0];
  endfunction

  function automatic token_t make_token(input ast_pkg::kind_t k, input logic [15:0] v,
                                        input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    token_t t;
    t.kind = k;
    t.value = v;
    t.first = a;
    t.second = b;
    t.third = c;
    t.line = line_cnt;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic token_t run_token();
    ast_pkg::kind_t k;
    logic [15:0]    v;
    logic [7:0]     c1;
    logic [7:0]     c2;
    k = ast_pkg::KIND_UNKNOWN;
    v = 16'd0;
    c1 = (run_len >= 3'd2) ? run_buf[1] : 8'd0;
    c2 = (run_len >= 3'd3) ? run_buf[2] : 8'd0;
    case (run_len)
      3'd1: begin
        if (run_buf[0] inside {"A", "a", "X", "x", "Y", "y"}) k = ast_pkg::KIND_REGISTER;
      end
      3'd2: begin
        if (hex_char(run_buf[0]) && hex_char(run_buf[1])) begin
          k = ast_pkg::KIND_BYTE;
          v = {8'd0, nibble(run_buf[0]), nibble(run_buf[1])};
        end
      end
      3'd3: k = ast_pkg::KIND_MNEMONIC;
      3'd4: begin
        if (hex_char(run_buf[0]) && hex_char(run_buf[1]) && hex_char(run_buf[2]) &&
            hex_char(run_buf[3])) begin
          k = ast_pkg::KIND_WORD;
          v = {nibble(run_buf[0]), nibble(run_buf[1]), nibble(run_buf[2]),
               nibble(run_buf[3])};
        end
      end
      default: k = ast_pkg::KIND_UNKNOWN;
    endcase
    return make_token(k, v, run_buf[0], c1, c2);
  endfunction

  task automatic clear_run();
    for (int i = 0; i < 4; i++) run_buf[i] = 8'd0;
    run_len = 3'd0;
  endtask

  task automatic append_token(input token_t t);
    expected_tokens.insert(expected_tokens.size(), t);
  endtask

  task automatic tokenize_char(input logic [7:0] c);
    token_t         run_tok;
    token_t         own_tok;
    logic           has_run;
    logic           has_own;
    ast_pkg::kind_t k;
    has_run = 1'b0;
    has_own = 1'b0;
    if (alnum_char(c)) begin
      if (run_len < 3'd4) run_buf[run_len[1:0]] = c;
      if (run_len < ast_pkg::RUN_MAX) run_len++;
      return;
    end
    if (run_len != 3'd0) begin
      run_tok = run_token();
      has_run = 1'b1;
      clear_run();
    end
    if (c inside {ast_pkg::CH_SPACE, ast_pkg::CH_TAB, ast_pkg::CH_VTAB, ast_pkg::CH_CR,
                  ast_pkg::CH_NEWLINE}) begin
      if (c == ast_pkg::CH_NEWLINE && line_cnt != ast_pkg::LINE_MAX) line_cnt++;
    end else if (c == ast_pkg::CH_NUL) begin
      own_tok = make_token(ast_pkg::KIND_END, 16'd0, 8'd0, 8'd0, 8'd0);
      has_own = 1'b1;
      line_cnt = ast_pkg::LINE_FIRST;
    end else begin
      case (c)
        ast_pkg::CH_HASH:   k = ast_pkg::KIND_HASH;
        ast_pkg::CH_DOLLAR: k = ast_pkg::KIND_DOLLAR;
        ast_pkg::CH_LPAREN: k = ast_pkg::KIND_LPAREN;
        ast_pkg::CH_RPAREN: k = ast_pkg::KIND_RPAREN;
        ast_pkg::CH_COMMA:  k = ast_pkg::KIND_COMMA;
        default:            k = ast_pkg::KIND_UNKNOWN;
      endcase
      own_tok = make_token(k, 16'd0, c, 8'd0, 8'd0);
      has_own = 1'b1;
    end
    if (has_own) own_tok.last = 1'b1;
    else run_tok.last = 1'b1;
    if (has_run) append_token(run_tok);
    if (has_own) append_token(own_tok);
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %h expected %h at word %0d", what, got, want, checked);
    fail_count++;
  endtask

  task automatic check_word();
    token_t e;
    if (expected_tokens.size() == 0) begin
      report("word with nothing expected, kind", 16'(token_kind), 16'd0);
      return;
    end
    e = expected_tokens.pop_front();
    if (token_kind != e.kind) report("kind", 16'(token_kind), 16'(e.kind));
    if (token_value != e.value) report("value", token_value, e.value);
    if (text_first != e.first) report("text_first", 16'(text_first), 16'(e.first));
    if (text_second != e.second) report("text_second", 16'(text_second), 16'(e.second));
    if (text_third != e.third) report("text_third", 16'(text_third), 16'(e.third));
    if (line_number != e.line) report("line", line_number, e.line);
    if (last_of_run != e.last) report("last_of_run", 16'(last_of_run), 16'(e.last));
    checked++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    clear_run();
    line_cnt = ast_pkg::LINE_FIRST;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_run();
      line_cnt = ast_pkg::LINE_FIRST;
      expected_tokens.delete();
    end else begin
      if (push && !full) tokenize_char(char_in);
      if (pop && !empty) check_word();
    end
    pending = expected_tokens.size();
  end

endmodule

>>> test/assembly_source_tokenizer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the assembly source tokenizer: drives directed and random source text
// under several idle/stall mixes and gives the verdict from tokenizer_checker.
// Depends on ast_pkg, assembly_source_tokenizer and tokenizer_checker.
module assembly_source_tokenizer_tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_CHARS = 320;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_char_in;
  logic        empty;
  logic        pop;
  logic [3:0]  out_token_kind;
  logic [15:0] out_token_value;
  logic [7:0]  out_text_first;
  logic [7:0]  out_text_second;
  logic [7:0]  out_text_third;
  logic [15:0] out_line_number;
  logic        out_last_of_run;

  int fail_count;
  int pending;
  int checked;
  int chars_sent;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int hold_reqs;
  int hold_seen;
  int target;
  logic [7:0] src_text[$];
  int send_idle_tbl[4] = '{0, 78, 0, 18};
  int recv_stall_tbl[4] = '{0, 0, 78, 18};

  assembly_source_tokenizer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_char_in      (in_char_in),
    .empty           (empty),
    .pop             (pop),
    .out_token_kind  (out_token_kind),
    .out_token_value (out_token_value),
    .out_text_first  (out_text_first),
    .out_text_second (out_text_second),
    .out_text_third  (out_text_third),
    .out_line_number (out_line_number),
    .out_last_of_run (out_last_of_run)
  );

  tokenizer_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .char_in     (in_char_in),
    .empty       (empty),
    .pop         (pop),
    .token_kind  (out_token_kind),
    .token_value (out_token_value),
    .text_first  (out_text_first),
    .text_second (out_text_second),
    .text_third  (out_text_third),
    .line_number (out_line_number),
    .last_of_run (out_last_of_run),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d pending", quiet_cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    pop = 1'b0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic add_char(input logic [7:0] c);
    src_text.insert(src_text.size(), c);
  endtask

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 10) return 8'(r) + "0";
    if (r < 36) return 8'(r - 10) + "A";
    return 8'(r - 36) + "a";
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(21);
    if (r < 10) return 8'(r) + "0";
    if (r < 16) return 8'(r - 10) + "A";
    return 8'(r - 16) + "a";
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(3))
      0: return ast_pkg::CH_SPACE;
      1: return ast_pkg::CH_TAB;
      2: return ast_pkg::CH_VTAB;
      default: return ast_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_reg();
    string regs;
    int    r;
    regs = "AaXxYy";
    r = $urandom_range(7);
    if (r < 6) return regs[r];
    return pick_alnum();
  endfunction

  function automatic logic [7:0] pick_delim();
    string d;
    int    r;
    d = "#$(), ";
    r = $urandom_range(8);
    if (r < 6) return d[r];
    if (r == 6) return ast_pkg::CH_NEWLINE;
    if (r == 7) return ast_pkg::CH_NUL;
    return 8'($urandom_range(255));
  endfunction

  // mostly instruction-shaped lines, some bare runs, some raw byte noise
  task automatic build_line();
    int form;
    int n;
    form = $urandom_range(9);
    if (form <= 5) begin
      repeat (3) add_char(pick_alnum());
      add_char(pick_space());
      case ($urandom_range(7))
        0: begin
          add_char(ast_pkg::CH_HASH);
          add_char(ast_pkg::CH_DOLLAR);
          repeat (2) add_char(pick_hex());
        end
        1: begin
          add_char(ast_pkg::CH_DOLLAR);
          repeat (4) add_char(pick_hex());
        end
        2: begin
          add_char(ast_pkg::CH_DOLLAR);
          repeat (4) add_char(pick_hex());
          add_char(ast_pkg::CH_COMMA);
          add_char(pick_reg());
        end
        3: begin
          add_char(ast_pkg::CH_LPAREN);
          add_char(ast_pkg::CH_DOLLAR);
          repeat (2) add_char(pick_hex());
          add_char(ast_pkg::CH_COMMA);
          add_char(pick_reg());
          add_char(ast_pkg::CH_RPAREN);
        end
        4: begin
          add_char(ast_pkg::CH_LPAREN);
          add_char(ast_pkg::CH_DOLLAR);
          repeat (2) add_char(pick_hex());
          add_char(ast_pkg::CH_RPAREN);
          add_char(ast_pkg::CH_COMMA);
          add_char(pick_reg());
        end
        5: add_char(pick_reg());
        6: ;
        default: begin
          add_char(ast_pkg::CH_HASH);
          repeat (2) add_char(pick_hex());
        end
      endcase
      if ($urandom_range(3) == 0) add_char(pick_space());
      add_char(($urandom_range(11) == 0) ? ast_pkg::CH_NUL : ast_pkg::CH_NEWLINE);
    end else if (form <= 7) begin
      n = $urandom_range(1, 9);
      repeat (n) add_char(pick_alnum());
      add_char(pick_delim());
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) add_char(8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_char_in = 8'd0;
    hold_reqs = 0;
    chars_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every kind, run lengths one to five, both hex cases, all blanks, high bytes, end
    send_str("A,x Gz#fF$LDA(09aB)abcde");
    send_char(ast_pkg::CH_NEWLINE);
    send_char(ast_pkg::CH_TAB);
    send_char(ast_pkg::CH_VTAB);
    send_char(ast_pkg::CH_CR);
    send_char(8'hFF);
    send_char(8'h80);
    send_str("y");
    send_char(ast_pkg::CH_NUL);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_tbl[ph];
      recv_stall_pct = recv_stall_tbl[ph];
      if (ph == 0) hold_reqs++;
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) begin
        build_line();
        while (src_text.size() > 0) send_char(src_text.pop_front());
      end
      drain();
    end

    // short texts ended right after a run and right after a delimiter
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_char(ast_pkg::CH_NUL);
    send_str("lda");
    send_char(ast_pkg::CH_NEWLINE);
    send_str("X");
    send_char(ast_pkg::CH_NUL);
    send_str("Y,");
    send_char(ast_pkg::CH_NUL);
    drain();

    repeat (20) @(negedge clk);
    $display("covered %0d characters and %0d tokens: directed text, four idle/stall mixes,",
             chars_sent, checked);
    $display("a long receiver hold-off with input back-pressure and end-of-text restarts");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
